// ----- src/hhls_pkg.sv -----
// Shared types, constants and helpers of the HTTP header length scanner.
package hhls_pkg;

  localparam int unsigned CntW = 21;
  localparam int unsigned NameLen = 15;
  localparam int unsigned NameStageW = 4;
  localparam int unsigned ProdW = CntW + 4;

  localparam logic [CntW-1:0] AbsLimit = CntW'(1024 * 1024);
  localparam logic [CntW-1:0] MinLimit = CntW'(16);

  localparam logic [7:0] ChCr = 8'h0D;
  localparam logic [7:0] ChLf = 8'h0A;
  localparam logic [7:0] CaseBit = 8'h20;

  typedef enum logic [2:0] {
    ST_HEADER_DONE   = 3'd0,
    ST_COMPLETE      = 3'd1,
    ST_LIMIT         = 3'd2,
    ST_NO_HEADER_END = 3'd3,
    ST_SHORT_BODY    = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    TERM_NONE  = 2'd0,
    TERM_CR    = 2'd1,
    TERM_CRLF  = 2'd2,
    TERM_CRLFCR = 2'd3
  } term_e;

  typedef struct packed {
    logic [CntW-1:0]       byte_count;
    term_e                 term_stage;
    logic [NameStageW-1:0] name_stage;
    logic                  in_value;
    logic [CntW-1:0]       length_value;
    logic [CntW-1:0]       header_length;
    logic                  in_body;
  } scan_state_t;

  typedef struct packed {
    logic            emit;
    status_e         status;
    logic [CntW-1:0] hdr_bytes;
    logic [CntW-1:0] content_length;
    logic [CntW-1:0] total_bytes;
  } scan_result_t;

  // Lowercase text of the field name, one character per match stage.
  function automatic logic [7:0] name_char(input logic [NameStageW-1:0] idx);
    logic [7:0] c;
    unique case (idx)
      4'd0:    c = "c";
      4'd1:    c = "o";
      4'd2:    c = "n";
      4'd3:    c = "t";
      4'd4:    c = "e";
      4'd5:    c = "n";
      4'd6:    c = "t";
      4'd7:    c = "-";
      4'd8:    c = "l";
      4'd9:    c = "e";
      4'd10:   c = "n";
      4'd11:   c = "g";
      4'd12:   c = "t";
      4'd13:   c = "h";
      4'd14:   c = ":";
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

// ----- src/hhls_step.sv -----
// Per-byte next-state and result logic of the header scanner.
module hhls_step (
  input  hhls_pkg::scan_state_t      state_i,
  input  logic [7:0]                 data_byte_i,
  input  logic                       end_of_data_i,
  input  logic [hhls_pkg::CntW-1:0]  limit_i,
  output hhls_pkg::scan_state_t      state_o,
  output hhls_pkg::scan_result_t     result_o
);

  hhls_pkg::scan_state_t           s;
  logic [7:0]                      low;
  logic [hhls_pkg::ProdW-1:0]      prod;
  logic [hhls_pkg::NameStageW-1:0] next_stage;
  logic                            is_digit;
  logic                            header_end;
  logic                            done;
  logic [hhls_pkg::CntW-1:0]       body_bytes;

  assign is_digit = (data_byte_i >= "0") && (data_byte_i <= "9");
  assign low = ((data_byte_i >= "A") && (data_byte_i <= "Z")) ?
               (data_byte_i + hhls_pkg::CaseBit) : data_byte_i;
  // length * 10 + digit
  assign prod = ({4'b0, state_i.length_value} << 3) + ({4'b0, state_i.length_value} << 1)
              + hhls_pkg::ProdW'(data_byte_i - "0");
  assign next_stage = state_i.name_stage + 1'b1;

  always_comb begin
    s = state_i;
    header_end = 1'b0;
    if (state_i.byte_count < limit_i) begin
      s.byte_count = state_i.byte_count + 1'b1;
    end

    if (!state_i.in_body) begin
      if (state_i.in_value) begin
        if (data_byte_i == hhls_pkg::ChCr || data_byte_i == hhls_pkg::ChLf) begin
          s.in_value = 1'b0;
        end else if (is_digit) begin
          s.length_value = (prod > hhls_pkg::ProdW'(limit_i)) ?
                           limit_i : prod[hhls_pkg::CntW-1:0];
        end
      end

      if (low == hhls_pkg::name_char(state_i.name_stage)) begin
        if (next_stage == hhls_pkg::NameStageW'(hhls_pkg::NameLen)) begin
          s.name_stage   = '0;
          s.in_value     = 1'b1;
          s.length_value = '0;
        end else begin
          s.name_stage = next_stage;
        end
      end else begin
        s.name_stage = (low == "c") ? hhls_pkg::NameStageW'(1) : '0;
      end

      priority if (data_byte_i == hhls_pkg::ChCr) begin
        s.term_stage = (state_i.term_stage == hhls_pkg::TERM_CRLF) ?
                       hhls_pkg::TERM_CRLFCR : hhls_pkg::TERM_CR;
      end else if (data_byte_i == hhls_pkg::ChLf &&
                   state_i.term_stage == hhls_pkg::TERM_CR) begin
        s.term_stage = hhls_pkg::TERM_CRLF;
      end else if (data_byte_i == hhls_pkg::ChLf &&
                   state_i.term_stage == hhls_pkg::TERM_CRLFCR) begin
        s.term_stage    = hhls_pkg::TERM_NONE;
        header_end      = 1'b1;
        s.in_body       = 1'b1;
        s.in_value      = 1'b0;
        s.name_stage    = '0;
        s.header_length = s.byte_count;
      end else begin
        s.term_stage = hhls_pkg::TERM_NONE;
      end
    end
  end

  assign body_bytes = s.byte_count - s.header_length;

  always_comb begin
    done            = 1'b1;
    result_o.emit   = 1'b1;
    result_o.status = hhls_pkg::ST_HEADER_DONE;
    priority if (s.in_body && body_bytes >= s.length_value) begin
      result_o.status = hhls_pkg::ST_COMPLETE;
    end else if (s.byte_count >= limit_i) begin
      result_o.status = hhls_pkg::ST_LIMIT;
    end else if (end_of_data_i) begin
      result_o.status = s.in_body ? hhls_pkg::ST_SHORT_BODY : hhls_pkg::ST_NO_HEADER_END;
    end else begin
      done          = 1'b0;
      result_o.emit = header_end;
    end
    result_o.hdr_bytes      = s.in_body ? s.header_length : s.byte_count;
    result_o.content_length = s.length_value;
    result_o.total_bytes    = s.byte_count;

    state_o = done ? '0 : s;
  end

endmodule

// ----- src/http_header_length_scanner.sv -----
// HTTP header length scanner: top level with input, state and result registers.
//
// Takes one request byte per cycle, except while a byte with a result waits for the
// output slot, and reports header end, completion, size limit and early end of data.
// An accepted byte is held in the input register; its result is loaded into the
// result register, from which it can transfer. The per-byte scan state loops back
// through the combinational step logic, which sets this rate.
// A waiting result in the output register does not block bytes that produce no
// result; only a byte that produces one stalls behind an untaken result. The size
// limit is clamped to 16..1048576 when written and takes effect on the next byte.
module http_header_length_scanner (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [hhls_pkg::CntW-1:0] max_request_bytes_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [7:0]                data_byte_i,
  input  logic                      end_of_data_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [2:0]                status_o,
  output logic [hhls_pkg::CntW-1:0] hdr_bytes_o,
  output logic [hhls_pkg::CntW-1:0] content_length_o,
  output logic [hhls_pkg::CntW-1:0] total_bytes_o
);

  logic                      in_valid_q;
  logic [7:0]                byte_q;
  logic                      eod_q;
  logic [hhls_pkg::CntW-1:0] limit_q, limit_d;
  hhls_pkg::scan_state_t     state_q, state_d;
  hhls_pkg::scan_result_t    res;
  logic                      out_valid_q;
  hhls_pkg::scan_result_t    out_q;
  logic                      advance;

  hhls_step u_step (
    .state_i       (state_q),
    .data_byte_i   (byte_q),
    .end_of_data_i (eod_q),
    .limit_i       (limit_q),
    .state_o       (state_d),
    .result_o      (res)
  );

  always_comb begin
    if (max_request_bytes_i < hhls_pkg::MinLimit) begin
      limit_d = hhls_pkg::MinLimit;
    end else if (max_request_bytes_i > hhls_pkg::AbsLimit) begin
      limit_d = hhls_pkg::AbsLimit;
    end else begin
      limit_d = max_request_bytes_i;
    end
  end

  // The held byte retires unless it has a result and the output slot stays full.
  assign advance    = in_valid_q && (!res.emit || !out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      limit_q     <= hhls_pkg::AbsLimit;
      state_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        limit_q <= limit_d;
      end
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (advance) begin
        state_q <= state_d;
      end
      if (advance && res.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      byte_q <= data_byte_i;
      eod_q  <= end_of_data_i;
    end
    if (advance && res.emit) begin
      out_q <= res;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = 3'(out_q.status);
  assign hdr_bytes_o      = out_q.hdr_bytes;
  assign content_length_o = out_q.content_length;
  assign total_bytes_o    = out_q.total_bytes;

endmodule

// ----- src/hhls_checker.sv -----
// Port-level checks of the header scanner, bound to the top level.
module hhls_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      out_valid_o,
  input logic                      out_ready_i,
  input logic [2:0]                status_o,
  input logic [hhls_pkg::CntW-1:0] hdr_bytes_o,
  input logic [hhls_pkg::CntW-1:0] total_bytes_o
);

  // A result waiting for its transfer stays put.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(total_bytes_o))
    else $error("result dropped or changed before transfer");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> status_o <= 3'(hhls_pkg::ST_SHORT_BODY))
    else $error("undefined status code");

  // Every result covers at least the byte that caused it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> total_bytes_o != '0)
    else $error("result with zero byte count");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> hdr_bytes_o <= total_bytes_o)
    else $error("header size exceeds total bytes");

  // The header-end report comes on the last header byte itself.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == 3'(hhls_pkg::ST_HEADER_DONE) |->
      hdr_bytes_o == total_bytes_o)
    else $error("header end reported after body bytes");

endmodule

bind http_header_length_scanner hhls_checker u_hhls_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .status_o      (status_o),
  .hdr_bytes_o   (hdr_bytes_o),
  .total_bytes_o (total_bytes_o)
);

// ----- tb/sv/testbench.sv -----
// Self-checking testbench for the HTTP header length scanner.
`timescale 1ns / 1ps

module testbench;
  import hhls_pkg::*;

  localparam int MaxCycles = 400000;
  localparam int ItemTarget = 1850;
  localparam logic [8*NameLen-1:0] FieldName = "content-length:";

  typedef struct packed {
    logic            emit;
    status_e         status;
    logic [CntW-1:0] hdr_bytes;
    logic [CntW-1:0] content_length;
    logic [CntW-1:0] total_bytes;
  } scan_report_t;

  logic            clk_i = 1'b0;
  logic            rst_ni = 1'b0;
  logic            cfg_we_i = 1'b0;
  logic [CntW-1:0] max_request_bytes_i = '0;
  logic            in_valid_i = 1'b0;
  logic            in_ready_o;
  logic [7:0]      data_byte_i = '0;
  logic            end_of_data_i = 1'b0;
  logic            out_valid_o;
  logic            out_ready_i = 1'b0;
  logic [2:0]      status_o;
  logic [CntW-1:0] hdr_bytes_o;
  logic [CntW-1:0] content_length_o;
  logic [CntW-1:0] total_bytes_o;

  http_header_length_scanner uut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .max_request_bytes_i(max_request_bytes_i),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .data_byte_i        (data_byte_i),
    .end_of_data_i      (end_of_data_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .status_o           (status_o),
    .hdr_bytes_o        (hdr_bytes_o),
    .content_length_o   (content_length_o),
    .total_bytes_o      (total_bytes_o)
  );

  always #5 clk_i = ~clk_i;

  // scanner state as predicted
  logic [CntW-1:0]       limit_reg;
  logic [CntW-1:0]       req_bytes;
  term_e                 term_st;
  logic [NameStageW-1:0] name_st;
  logic                  in_value;
  logic [CntW-1:0]       length_acc;
  logic [CntW-1:0]       hdr_len;
  logic                  in_body;

  scan_report_t expected_reports[$];
  logic [7:0]   req_q[$];
  scan_report_t want;

  int fail_count = 0;
  int cycle_count = 0;
  int bytes_sent = 0;
  int results_seen = 0;
  int status_seen[8];
  int config_writes = 0;
  int burst_left = 0;
  bit no_gaps = 1'b0;
  int hold_cycles = 0;
  int stall_pct = 0;
  int pattern_left = 0;

  function automatic void clear_scan();
    req_bytes  = '0;
    term_st    = TERM_NONE;
    name_st    = '0;
    in_value   = 1'b0;
    length_acc = '0;
    hdr_len    = '0;
    in_body    = 1'b0;
  endfunction

  function automatic scan_report_t scan_byte(input logic [7:0] b, input logic eod);
    logic [CntW-1:0]  lim;
    logic [7:0]       low;
    logic [ProdW-1:0] prod;
    logic             hdr_end;
    logic             done;
    scan_report_t     r;
    lim = limit_reg;
    if (lim < MinLimit) lim = MinLimit;
    else if (lim > AbsLimit) lim = AbsLimit;
    hdr_end = 1'b0;
    done = 1'b0;
    r = '0;
    if (req_bytes < lim) req_bytes = req_bytes + 1'b1;
    if (!in_body) begin
      low = (b >= "A" && b <= "Z") ? (b | CaseBit) : b;
      if (in_value) begin
        if (b == ChCr || b == ChLf) begin
          in_value = 1'b0;
        end else if (b >= "0" && b <= "9") begin
          prod = ProdW'(length_acc) * ProdW'(10) + ProdW'(b - "0");
          length_acc = (prod > ProdW'(lim)) ? lim : prod[CntW-1:0];
        end
      end
      if (name_st < NameLen && low == FieldName[8*(NameLen-1-name_st) +: 8]) begin
        name_st = name_st + 1'b1;
        if (name_st == NameLen) begin
          name_st = '0;
          in_value = 1'b1;
          length_acc = '0;
        end
      end else begin
        name_st = (low == "c") ? NameStageW'(1) : '0;
      end
      if (b == ChCr) begin
        term_st = (term_st == TERM_CRLF) ? TERM_CRLFCR : TERM_CR;
      end else if (b == ChLf && term_st == TERM_CR) begin
        term_st = TERM_CRLF;
      end else if (b == ChLf && term_st == TERM_CRLFCR) begin
        term_st = TERM_NONE;
        hdr_end = 1'b1;
        in_body = 1'b1;
        in_value = 1'b0;
        name_st = '0;
        hdr_len = req_bytes;
      end else begin
        term_st = TERM_NONE;
      end
    end
    // event priority: completion, size cap, end of data, header end
    if (in_body && (req_bytes - hdr_len) >= length_acc) begin
      done = 1'b1;
      r.status = ST_COMPLETE;
    end else if (req_bytes >= lim) begin
      done = 1'b1;
      r.status = ST_LIMIT;
    end else if (eod) begin
      done = 1'b1;
      r.status = in_body ? ST_SHORT_BODY : ST_NO_HEADER_END;
    end else if (hdr_end) begin
      r.status = ST_HEADER_DONE;
    end
    r.emit = done | hdr_end;
    r.hdr_bytes = in_body ? hdr_len : req_bytes;
    r.content_length = length_acc;
    r.total_bytes = req_bytes;
    if (done) clear_scan();
    return r;
  endfunction

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= MaxCycles) begin
      $display("%0t: timeout after %0d cycles", $time, cycle_count);
      $display("== FAIL ==");
      $finish;
    end
  end

  // receiver: long hold-offs on request, otherwise a changing stall rate
  always @(negedge clk_i) begin
    if (hold_cycles > 0) begin
      hold_cycles--;
      out_ready_i <= 1'b0;
    end else begin
      if (pattern_left == 0) begin
        pattern_left = $urandom_range(16, 96);
        case ($urandom_range(0, 3))
          0:       stall_pct = 0;
          1:       stall_pct = 25;
          2:       stall_pct = 60;
          default: stall_pct = 90;
        endcase
      end
      pattern_left--;
      out_ready_i <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  task automatic check_field(input string what, input logic [CntW-1:0] exp_v,
                             input logic [CntW-1:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch: expected %0d actual %0d", $time, what, exp_v, act_v);
      fail_count++;
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_reports.size() == 0) begin
        $display("%0t: unexpected result: status %0d header %0d length %0d total %0d",
                 $time, status_o, hdr_bytes_o, content_length_o, total_bytes_o);
        fail_count++;
      end else begin
        want = expected_reports.pop_front();
        results_seen++;
        status_seen[status_o]++;
        check_field("status", CntW'(want.status), CntW'(status_o));
        check_field("hdr_bytes", want.hdr_bytes, hdr_bytes_o);
        check_field("content_length", want.content_length, content_length_o);
        check_field("total_bytes", want.total_bytes, total_bytes_o);
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic eod);
    int gap;
    scan_report_t r;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 48);
      gap = (no_gaps || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        @(negedge clk_i) in_valid_i <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
    end
    burst_left--;
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    data_byte_i <= b;
    end_of_data_i <= eod;
    do @(posedge clk_i); while (!in_ready_o);
    bytes_sent++;
    r = scan_byte(b, eod);
    if (r.emit) expected_reports.push_back(r);
  endtask

  // stop offering bytes and wait for every pending result
  task automatic drain();
    @(negedge clk_i) in_valid_i <= 1'b0;
    while (expected_reports.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_limit(input logic [CntW-1:0] v);
    drain();
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    max_request_bytes_i <= v;
    @(negedge clk_i) cfg_we_i <= 1'b0;
    limit_reg = v;
    config_writes++;
  endtask

  task automatic push_text(input string s, input bit mix_case);
    logic [7:0] c;
    for (int i = 0; i < s.len(); i++) begin
      c = s[i];
      if (mix_case && ((c >= "a" && c <= "z") || (c >= "A" && c <= "Z")) &&
          $urandom_range(0, 1) == 1)
        c = c ^ CaseBit;
      req_q.push_back(c);
    end
  endtask

  task automatic push_line(input string s, input bit mix_case);
    push_text(s, mix_case);
    req_q.push_back(ChCr);
    req_q.push_back(ChLf);
  endtask

  task automatic send_request(input logic eod_last);
    logic [7:0] b;
    while (req_q.size() != 0) begin
      b = req_q.pop_front();
      send_byte(b, eod_last && req_q.size() == 0);
    end
  endtask

  task automatic push_filler();
    case ($urandom_range(0, 5))
      0: push_line("Host: node", 1'b1);
      1: push_line("Accept: */*", 1'b0);
      2: push_line("X-Content-Lengthy: 7", 1'b1);
      3: push_line("Cookie: c=ccontent-lengt", 1'b1);
      4: begin
        push_text("Via: 1", 1'b0);
        req_q.push_back(ChCr);
        push_line("", 1'b0);
      end
      default: push_line("Content-Type: text", 1'b1);
    endcase
  endtask

  task automatic push_length_field(input int unsigned value);
    string digits;
    push_text("content-length:", 1'b1);
    repeat ($urandom_range(0, 2)) req_q.push_back(" ");
    if ($urandom_range(0, 7) == 0) req_q.push_back("0");
    digits = $sformatf("%0d", value);
    for (int i = 0; i < digits.len(); i++) begin
      req_q.push_back(digits[i]);
      if ($urandom_range(0, 9) == 0)
        req_q.push_back($urandom_range(0, 1) ? 8'h78 : 8'($urandom_range(128, 255)));
    end
    // now and then the value runs on into a second field on the same line
    if ($urandom_range(0, 4) != 0) push_line("", 1'b0);
  endtask

  task automatic build_request(output logic eod_last);
    int          kind;
    int          body_len;
    int unsigned declared;
    kind = $urandom_range(0, 9);
    eod_last = 1'b0;
    declared = 0;
    if (kind == 0) begin
      repeat ($urandom_range(1, 24)) req_q.push_back(8'($urandom_range(0, 255)));
      eod_last = $urandom_range(0, 1);
    end else begin
      push_text("GET /", 1'b0);
      repeat ($urandom_range(0, 6)) req_q.push_back(8'($urandom_range(97, 122)));
      push_line(" HTTP/1.1", 1'b0);
      repeat ($urandom_range(0, 3)) push_filler();
      if ($urandom_range(0, 9) < 7) begin
        repeat ($urandom_range(1, 2)) begin
          case ($urandom_range(0, 9))
            7, 8:    declared = $urandom_range(25, 200);
            9:       declared = $urandom;
            default: declared = $urandom_range(0, 24);
          endcase
          push_length_field(declared);
          if ($urandom_range(0, 1)) push_filler();
        end
      end
      if (kind == 1) begin
        eod_last = 1'b1;
      end else begin
        push_line("", 1'b0);
        body_len = $urandom_range(0, 9);
        if (declared > 64) begin
          body_len = $urandom_range(0, 20);
          eod_last = 1'b1;
        end else if (body_len < 6) begin
          body_len = declared;
        end else if (body_len < 8) begin
          body_len = $urandom_range(0, declared);
          eod_last = 1'b1;
        end else begin
          body_len = declared + $urandom_range(1, 5);
        end
        repeat (body_len) req_q.push_back(8'($urandom_range(0, 255)));
      end
    end
  endtask

  task automatic test_zero_length_body();
    push_line("", 1'b0);
    push_line("", 1'b0);
    send_request(1'b0);
  endtask

  task automatic test_declared_body();
    push_line("CONTENT-LENGTH: 12content-length:2", 1'b0);
    push_line("", 1'b0);
    push_text("xy", 1'b0);
    send_request(1'b0);
  endtask

  task automatic test_end_of_data();
    push_text("ab", 1'b0);
    send_request(1'b1);
    push_line("content-length:9", 1'b0);
    push_line("", 1'b0);
    send_request(1'b1);
    push_line("Content-Length:9", 1'b0);
    push_line("", 1'b0);
    push_text("q", 1'b0);
    send_request(1'b1);
  endtask

  task automatic test_high_bytes();
    req_q.push_back(8'h80);
    req_q.push_back(8'hE3);
    req_q.push_back(8'hFF);
    push_text("content-length:7", 1'b0);
    req_q.push_back(8'hB5);
    push_line("", 1'b0);
    push_line("", 1'b0);
    repeat (6) req_q.push_back(8'hFF);
    req_q.push_back(8'h00);
    send_request(1'b0);
  endtask

  task automatic test_limit_settings();
    write_limit('0);
    repeat (16) req_q.push_back("a");
    send_request(1'b1);
    write_limit(CntW'(15));
    push_text("content-length:999", 1'b0);
    send_request(1'b0);
    // header end and size cap fall on the same byte
    write_limit(CntW'(20));
    push_line("content-length:1", 1'b0);
    push_line("", 1'b0);
    send_request(1'b0);
    // completion and size cap on the same byte
    write_limit(CntW'(21));
    push_line("content-length:1", 1'b0);
    push_line("", 1'b0);
    push_text("Z", 1'b0);
    send_request(1'b0);
    write_limit('1);
    push_line("content-length:99999999", 1'b0);
    push_line("", 1'b0);
    push_text("ab", 1'b0);
    send_request(1'b1);
    write_limit(AbsLimit + 1'b1);
    push_line("content-length:1048577", 1'b0);
    push_line("", 1'b0);
    send_request(1'b1);
    write_limit(CntW'(17));
    push_line("content-length:3", 1'b0);
    send_request(1'b1);
    write_limit(AbsLimit);
  endtask

  // output held off while results keep coming, so the input must stall
  task automatic test_backpressure();
    drain();
    no_gaps = 1'b1;
    hold_cycles = 200;
    repeat (3) send_byte("x", 1'b1);
    push_text("abc", 1'b0);
    send_request(1'b0);
    repeat (24) send_byte(8'($urandom_range(0, 255)), 1'b1);
    no_gaps = 1'b0;
    drain();
  endtask

  // random requests until the byte budget of the whole run is used up
  task automatic test_random_requests();
    logic eodl;
    while (bytes_sent < ItemTarget) begin
      case ($urandom_range(0, 5))
        0:       write_limit(CntW'($urandom_range(16, 48)));
        1:       write_limit(CntW'($urandom_range(0, 15)));
        2:       write_limit(CntW'($urandom_range(100, 400)));
        3:       write_limit(AbsLimit);
        4:       write_limit(CntW'($urandom_range(0, 2097151)));
        default: write_limit(CntW'($urandom_range(49, 99)));
      endcase
      repeat ($urandom_range(4, 12)) begin
        if (bytes_sent < ItemTarget) begin
          build_request(eodl);
          send_request(eodl);
        end
      end
    end
  endtask

  initial begin
    limit_reg = AbsLimit;
    clear_scan();
    repeat (12) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;
    test_zero_length_body();
    test_declared_body();
    test_end_of_data();
    test_high_bytes();
    test_limit_settings();
    test_backpressure();
    test_random_requests();
    drain();
    $display("Sent %0d request bytes over %0d limit settings; %0d results checked.",
             bytes_sent, config_writes, results_seen);
    $display("By status: header %0d, complete %0d, cap %0d, no end %0d, short %0d.",
             status_seen[ST_HEADER_DONE], status_seen[ST_COMPLETE], status_seen[ST_LIMIT],
             status_seen[ST_NO_HEADER_END], status_seen[ST_SHORT_BODY]);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ----- files.f -----
src/hhls_pkg.sv
src/hhls_step.sv
src/http_header_length_scanner.sv
src/hhls_checker.sv
tb/sv/testbench.sv
